### rtl/gradient_noise_3d_defines.svh
// assertion macros for the gradient noise block
// used by gradient_noise_3d, expects i_clk and i_rst_n in scope
`ifndef GRADIENT_NOISE_3D_DEFINES_SVH
`define GRADIENT_NOISE_3D_DEFINES_SVH

// same-cycle implication
`define GN3_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gn3 check failed");

// next-cycle implication
`define GN3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gn3 check failed");

`endif

### rtl/gn3_pkg.sv
// shared constants, types and arithmetic helpers for the gradient noise block
// no dependencies
`default_nettype none

package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int SEED_W    = 32;
    localparam int OUT_W     = 18;
    localparam int NUM_STG   = 7;
    localparam int NUM_CRN   = 8;
    localparam int FADE_W    = FRAC_BITS + 2;
    localparam int OFS_W     = FRAC_BITS + 2;
    localparam int VAL_W     = FRAC_BITS + 4;
    localparam int HLO_W     = 16;

    localparam logic [31:0] K_X = 32'h27d4eb2d;
    localparam logic [31:0] K_Y = 32'h85ebca6b;
    localparam logic [31:0] K_Z = 32'h165667b1;
    localparam logic [31:0] K_M = 32'h2c1b3c6d;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [FADE_W-1:0] t_fade;
    typedef logic signed [OFS_W-1:0]  t_ofs;

    typedef struct packed {
        logic [NUM_STG-1:0] en;
    } t_pipe_ctl;

    localparam t_val OUT_MAX = t_val'((1 << (OUT_W - 1)) - 1);
    localparam t_val OUT_MIN = -t_val'(1 << (OUT_W - 1));

    function automatic t_val corner_dot(logic [3:0] idx, t_ofs dx, t_ofs dy, t_ofs dz);
        t_val ex;
        t_val ey;
        t_val ez;
        t_val res;
        ex = t_val'(dx);
        ey = t_val'(dy);
        ez = t_val'(dz);
        case (idx)
            4'd0:    res = ex + ey;
            4'd1:    res = -ex + ey;
            4'd2:    res = ex - ey;
            4'd3:    res = -ex - ey;
            4'd4:    res = ex + ez;
            4'd5:    res = -ex + ez;
            4'd6:    res = ex - ez;
            4'd7:    res = -ex - ez;
            4'd8:    res = ey + ez;
            4'd9:    res = -ey + ez;
            4'd10:   res = ey - ez;
            4'd11:   res = -ey - ez;
            4'd12:   res = ex + ey;
            4'd13:   res = -ex + ey;
            4'd14:   res = -ey + ez;
            4'd15:   res = -ey - ez;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic t_val lerp(t_val a, t_val b, t_fade t);
        logic signed [VAL_W:0]        d;
        logic signed [VAL_W+FADE_W:0] p;
        d = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
        p = d * t;
        return a + t_val'(p >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

### rtl/gn3_fade.sv
// fade curve 6t^5 - 15t^4 + 10t^3 in three register stages
// depends on gn3_pkg
`default_nettype none

module gn3_fade import gn3_pkg::*; (
    input  wire logic                 i_clk,
    input  wire t_pipe_ctl            i_ctl,
    input  wire logic [FRAC_BITS-1:0] i_t,
    output t_fade                     o_fade
);

    localparam int INN_W = FRAC_BITS + 5;
    localparam logic signed [INN_W-1:0] FIFTEEN = INN_W'(15 * (1 << FRAC_BITS));
    localparam logic signed [INN_W-1:0] TEN     = INN_W'(10 * (1 << FRAC_BITS));

    logic signed [INN_W-1:0]           w_inner;
    logic signed [INN_W+FRAC_BITS:0]   w_p1;
    logic        [2*FRAC_BITS-1:0]     w_sq;
    logic        [2*FRAC_BITS-1:0]     w_cube;
    logic signed [INN_W+FRAC_BITS:0]   w_p3;

    logic signed [INN_W-1:0]   r_a;
    logic        [FRAC_BITS-1:0] r_tt;
    logic        [FRAC_BITS-1:0] r_t1;
    logic signed [INN_W-1:0]   r_poly;
    logic        [FRAC_BITS-1:0] r_t3;
    t_fade                     r_fade;

    assign w_inner = $signed(INN_W'({i_t, 2'b00}) + INN_W'({i_t, 1'b0})) - FIFTEEN;
    assign w_p1    = $signed({1'b0, i_t}) * w_inner;
    assign w_sq    = i_t * i_t;
    assign w_cube  = r_tt * r_t1;
    assign w_p3    = $signed({1'b0, r_t3}) * r_poly;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_a  <= INN_W'(w_p1 >>> FRAC_BITS);
            r_tt <= w_sq[2*FRAC_BITS-1:FRAC_BITS];
            r_t1 <= i_t;
        end
        if (i_ctl.en[2]) begin
            r_poly <= r_a + TEN;
            r_t3   <= w_cube[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (i_ctl.en[3]) begin
            r_fade <= FADE_W'(w_p3 >>> FRAC_BITS);
        end
    end

    assign o_fade = r_fade;

endmodule

`default_nettype wire

### rtl/gn3_corner.sv
// corner hashing and gradient dot products in three register stages
// depends on gn3_pkg
`default_nettype none

module gn3_corner import gn3_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_pipe_ctl          i_ctl,
    input  wire logic [COORD_W-1:0] i_x,
    input  wire logic [COORD_W-1:0] i_y,
    input  wire logic [COORD_W-1:0] i_z,
    input  wire logic [SEED_W-1:0]  i_seed,
    output t_val                    o_dot [NUM_CRN]
);

    localparam t_ofs ONE = t_ofs'(1 << FRAC_BITS);

    logic [31:0] w_cx;
    logic [31:0] w_cy;
    logic [31:0] w_cz;
    logic [31:0] w_mx1;
    logic [31:0] w_my1;
    logic [31:0] w_mz1;

    logic [31:0]          r_mx;
    logic [31:0]          r_my;
    logic [31:0]          r_mz;
    logic [SEED_W-1:0]    r_seed;
    logic [FRAC_BITS-1:0] r1_fx;
    logic [FRAC_BITS-1:0] r1_fy;
    logic [FRAC_BITS-1:0] r1_fz;
    logic [HLO_W-1:0]     r_hl [NUM_CRN];
    logic [HLO_W-1:0]     n_hl [NUM_CRN];
    logic [FRAC_BITS-1:0] r2_fx;
    logic [FRAC_BITS-1:0] r2_fy;
    logic [FRAC_BITS-1:0] r2_fz;
    t_val                 r_dot [NUM_CRN];
    t_val                 n_dot [NUM_CRN];

    assign w_cx  = 32'($signed(i_x[COORD_W-1:FRAC_BITS]));
    assign w_cy  = 32'($signed(i_y[COORD_W-1:FRAC_BITS]));
    assign w_cz  = 32'($signed(i_z[COORD_W-1:FRAC_BITS]));
    assign w_mx1 = r_mx + K_X;
    assign w_my1 = r_my + K_Y;
    assign w_mz1 = r_mz + K_Z;

    always_comb begin
        logic [31:0]      h;
        logic [31:0]      h2;
        logic [2*HLO_W-1:0] p;
        for (int c = 0; c < NUM_CRN; c++) begin
            h = r_seed ^ (((c & 1) != 0) ? w_mx1 : r_mx)
                       ^ (((c & 2) != 0) ? w_my1 : r_my)
                       ^ (((c & 4) != 0) ? w_mz1 : r_mz);
            h2 = h ^ (h >> 15);
            p = h2[HLO_W-1:0] * K_M[HLO_W-1:0];
            n_hl[c] = p[HLO_W-1:0];
        end
    end

    always_comb begin
        t_ofs       fx;
        t_ofs       fy;
        t_ofs       fz;
        t_ofs       dx;
        t_ofs       dy;
        t_ofs       dz;
        logic [3:0] idx;
        fx = t_ofs'({1'b0, r2_fx});
        fy = t_ofs'({1'b0, r2_fy});
        fz = t_ofs'({1'b0, r2_fz});
        for (int c = 0; c < NUM_CRN; c++) begin
            dx = ((c & 1) != 0) ? fx - ONE : fx;
            dy = ((c & 2) != 0) ? fy - ONE : fy;
            dz = ((c & 4) != 0) ? fz - ONE : fz;
            idx = r_hl[c][3:0] ^ r_hl[c][HLO_W-1:HLO_W-4];
            n_dot[c] = corner_dot(idx, dx, dy, dz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_mx   <= w_cx * K_X;
            r_my   <= w_cy * K_Y;
            r_mz   <= w_cz * K_Z;
            r_seed <= i_seed;
            r1_fx  <= i_x[FRAC_BITS-1:0];
            r1_fy  <= i_y[FRAC_BITS-1:0];
            r1_fz  <= i_z[FRAC_BITS-1:0];
        end
        if (i_ctl.en[2]) begin
            r_hl  <= n_hl;
            r2_fx <= r1_fx;
            r2_fy <= r1_fy;
            r2_fz <= r1_fz;
        end
        if (i_ctl.en[3]) begin
            r_dot <= n_dot;
        end
    end

    assign o_dot = r_dot;

endmodule

`default_nettype wire

### rtl/gn3_blend.sv
// trilinear blend of the corner values and output saturation, three stages
// depends on gn3_pkg
`default_nettype none

module gn3_blend import gn3_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_val      i_dot [NUM_CRN],
    input  wire t_fade     i_u,
    input  wire t_fade     i_v,
    input  wire t_fade     i_w,
    output logic [OUT_W-1:0] o_value
);

    t_val  r_nx [4];
    t_fade r4_v;
    t_fade r4_w;
    t_val  r_ny0;
    t_val  r_ny1;
    t_fade r5_w;
    logic [OUT_W-1:0] r_value;
    t_val  w_r;

    assign w_r = lerp(r_ny0, r_ny1, r5_w);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            for (int k = 0; k < 4; k++) begin
                r_nx[k] <= lerp(i_dot[2*k], i_dot[2*k+1], i_u);
            end
            r4_v <= i_v;
            r4_w <= i_w;
        end
        if (i_ctl.en[5]) begin
            r_ny0 <= lerp(r_nx[0], r_nx[1], r4_v);
            r_ny1 <= lerp(r_nx[2], r_nx[3], r4_v);
            r5_w  <= r4_w;
        end
        if (i_ctl.en[6]) begin
            if (w_r > OUT_MAX) begin
                r_value <= OUT_MAX[OUT_W-1:0];
            end else if (w_r < OUT_MIN) begin
                r_value <= OUT_MIN[OUT_W-1:0];
            end else begin
                r_value <= w_r[OUT_W-1:0];
            end
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### rtl/gradient_noise_3d.sv
// channel | bits | contents
// s_axis  | 128  | tdata: coord_x, coord_y, coord_z, noise_seed
// m_axis  | 24   | tdata: noise_value (18 bits), zero padded
// seven register stages, one point per cycle sustained while the output is not held
// stage ready is chained: a stage loads when empty or when the next stage moves
// a held output stalls only the stages behind it that are full
// reset clears the valid bits only; no state between words
// depends on gn3_pkg, gn3_corner, gn3_fade, gn3_blend, gradient_noise_3d_defines.svh
`default_nettype none
`include "gradient_noise_3d_defines.svh"

module gradient_noise_3d import gn3_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // coord_x, coord_y, coord_z, noise_seed
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata    // noise_value, zero pad
);

    t_pipe_ctl          w_ctl;
    logic [NUM_STG-1:0] r_vld;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic [SEED_W-1:0]  r_seed;
    t_val               w_dot [NUM_CRN];
    t_fade              w_u;
    t_fade              w_v;
    t_fade              w_w;
    logic [OUT_W-1:0]   w_value;

    always_comb begin
        w_ctl.en[NUM_STG-1] = !r_vld[NUM_STG-1] || m_axis_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_x    <= s_axis_tdata[31:0];
            r_y    <= s_axis_tdata[63:32];
            r_z    <= s_axis_tdata[95:64];
            r_seed <= s_axis_tdata[127:96];
        end
    end

    gn3_corner u_corner (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_z    (r_z),
        .i_seed (r_seed),
        .o_dot  (w_dot)
    );

    gn3_fade u_fade_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_t    (r_x[FRAC_BITS-1:0]),
        .o_fade (w_u)
    );

    gn3_fade u_fade_y (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_t    (r_y[FRAC_BITS-1:0]),
        .o_fade (w_v)
    );

    gn3_fade u_fade_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_t    (r_z[FRAC_BITS-1:0]),
        .o_fade (w_w)
    );

    gn3_blend u_blend (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_dot   (w_dot),
        .i_u     (w_u),
        .i_v     (w_v),
        .i_w     (w_w),
        .o_value (w_value)
    );

    assign s_axis_tready = w_ctl.en[0];
    assign m_axis_tvalid = r_vld[NUM_STG-1];
    assign m_axis_tdata  = {(24 - OUT_W)'(0), w_value};

    `GN3_ASSERT_NOW(a_full_stall, (&r_vld) && !m_axis_tready, !s_axis_tready)
    `GN3_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, r_vld[0])
    `GN3_ASSERT_NEXT(a_stage_moves, r_vld[NUM_STG-2] && w_ctl.en[NUM_STG-1], m_axis_tvalid)

endmodule

`default_nettype wire
